/* hdl/psf_pkg.sv */
`timescale 1ns / 1ps

package psf_pkg;

  // Field widths of one input item and one result item.
  localparam int IDX_W    = 10;
  localparam int ROLL_W   = 7;
  localparam int THR_W    = 7;
  localparam int FADE_W   = 8;
  localparam int CHAN_W   = 8;
  localparam int COLOR_W  = 3 * CHAN_W;

  // Configuration port geometry: four 32-bit registers at byte offsets 0..12.
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 4;

  localparam int PIXELS_DEF = 1024;

  // Reset values of the registers.
  localparam logic [THR_W-1:0]   SPARKLE_THR_RST = 7'd20;
  localparam logic [THR_W-1:0]   RESET_EXTRA_RST = 7'd8;
  localparam logic [FADE_W-1:0]  FADE_RST        = 8'd200;
  localparam logic [COLOR_W-1:0] BACKGROUND_RST  = 24'd0;

  typedef enum logic [1:0] {
    REG_SPARKLE_THR = 2'd0,
    REG_RESET_EXTRA = 2'd1,
    REG_FADE        = 2'd2,
    REG_BACKGROUND  = 2'd3
  } cfg_reg_t;

  localparam int FADE_DIV = 255 * 255;

  // Step for every fade setting: max(1, (255 - fade)^3 / 65025), built at elaboration.
  function automatic logic [255:0][CHAN_W-1:0] build_step_tbl();
    logic [255:0][CHAN_W-1:0] tbl;
    int inv;
    int quo;
    for (int i = 0; i < 256; i++) begin
      inv = 255 - i;
      quo = inv * inv * inv / FADE_DIV;
      tbl[i] = (quo < 1) ? CHAN_W'(1) : CHAN_W'(quo);
    end
    return tbl;
  endfunction

  localparam logic [255:0][CHAN_W-1:0] SLEW_STEP_TBL = build_step_tbl();

  // Moves one channel toward its target by at most one step.
  function automatic logic [CHAN_W-1:0] chan_move(input logic [CHAN_W-1:0] from,
                                                  input logic [CHAN_W-1:0] to,
                                                  input logic [CHAN_W-1:0] step);
    logic [CHAN_W-1:0] res;
    if (from < to) begin
      res = ((to - from) <= step) ? to : from + step;
    end else begin
      res = ((from - to) <= step) ? to : from - step;
    end
    return res;
  endfunction

endpackage

/* hdl/psf_ram.sv */
`timescale 1ns / 1ps

module psf_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Read data holds while no read is issued; a read of the entry being
  // written returns the old contents.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* hdl/pixel_sparkle_fader_top.sv */
`timescale 1ns / 1ps

// Per-pixel sparkle fader. Each input item names one pixel, optionally
// restarts it to the background color and optionally rerolls its target
// color from the supplied roll. Every channel of the pixel's current color
// then moves toward its target by the fade step, and one result item carries
// the pixel index and its new red, green and blue values.
// Both channels use valid and stall; an item moves at an edge where valid is
// high and stall is low. The user must write the registers over the APB-style
// port only while no item is in flight; the block does not enforce this.
// The edge that accepts an item issues the synchronous read of the target and
// current stores; the edge at which stage one fires registers the updated
// colors in the output register, writes them back and raises out_valid.
// With out_stall low the block takes one item every cycle; a write back to the
// same pixel as the next item's read is forwarded, so back-to-back items on one
// pixel need no bubble.
// When out_stall holds a result, the update stage holds its item and in_stall
// rises once that stage is occupied, so one more item is absorbed first.
// Reset clears the pipeline and loads the register defaults. The stores are
// not cleared: a pixel must see a restart item before its colors mean anything.
module pixel_sparkle_fader_top #(
  parameter int PIXELS = psf_pkg::PIXELS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // Input item channel.
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [psf_pkg::IDX_W-1:0]          in_pixel_index,
  input  logic                               in_restart,
  input  logic                               in_new_period,
  input  logic [psf_pkg::ROLL_W-1:0]         in_roll,
  input  logic [psf_pkg::COLOR_W-1:0]        in_sparkle_color,
  // Result item channel.
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [psf_pkg::IDX_W-1:0]          out_index,
  output logic [psf_pkg::CHAN_W-1:0]         out_red,
  output logic [psf_pkg::CHAN_W-1:0]         out_green,
  output logic [psf_pkg::CHAN_W-1:0]         out_blue,
  // Configuration port.
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [psf_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [psf_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [psf_pkg::APB_DATA_W-1:0]     prdata,
  output logic                               pready
);

  localparam int AW     = (PIXELS > 1) ? $clog2(PIXELS) : 1;
  localparam int CW     = psf_pkg::CHAN_W;
  localparam int COLORW = psf_pkg::COLOR_W;

  // ---------------------------------------------------------------------------
  // Configuration registers. The fade step is looked up when the fade setting
  // is written, so it is ready for the very next item.
  // ---------------------------------------------------------------------------
  logic [psf_pkg::THR_W-1:0]  sparkle_thr_r;
  logic [psf_pkg::THR_W-1:0]  reset_extra_r;
  logic [psf_pkg::FADE_W-1:0] fade_r;
  logic [COLORW-1:0]          background_r;
  logic [CW-1:0]              step_r;
  logic                       cfg_wr;
  psf_pkg::cfg_reg_t          cfg_sel;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_sel = psf_pkg::cfg_reg_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sparkle_thr_r <= psf_pkg::SPARKLE_THR_RST;
      reset_extra_r <= psf_pkg::RESET_EXTRA_RST;
      fade_r        <= psf_pkg::FADE_RST;
      background_r  <= psf_pkg::BACKGROUND_RST;
      step_r        <= psf_pkg::SLEW_STEP_TBL[psf_pkg::FADE_RST];
    end else if (cfg_wr) begin
      case (cfg_sel)
        psf_pkg::REG_SPARKLE_THR: begin
          sparkle_thr_r <= pwdata[psf_pkg::THR_W-1:0];
        end
        psf_pkg::REG_RESET_EXTRA: begin
          reset_extra_r <= pwdata[psf_pkg::THR_W-1:0];
        end
        psf_pkg::REG_FADE: begin
          fade_r <= pwdata[psf_pkg::FADE_W-1:0];
          step_r <= psf_pkg::SLEW_STEP_TBL[pwdata[psf_pkg::FADE_W-1:0]];
        end
        psf_pkg::REG_BACKGROUND: begin
          background_r <= pwdata[COLORW-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (cfg_sel)
      psf_pkg::REG_SPARKLE_THR: prdata = psf_pkg::APB_DATA_W'(sparkle_thr_r);
      psf_pkg::REG_RESET_EXTRA: prdata = psf_pkg::APB_DATA_W'(reset_extra_r);
      psf_pkg::REG_FADE:        prdata = psf_pkg::APB_DATA_W'(fade_r);
      psf_pkg::REG_BACKGROUND:  prdata = psf_pkg::APB_DATA_W'(background_r);
      default:                  prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Pipeline control. Stage one holds the item whose store contents are being
  // read; it moves on whenever the output register is free or being drained.
  // ---------------------------------------------------------------------------
  logic s1_v_r, s1_v_nxt;
  logic out_v_r;
  logic s1_adv;
  logic s1_fire;
  logic in_fire;

  assign s1_adv   = !out_v_r || !out_stall;
  assign s1_fire  = s1_v_r && s1_adv;
  assign in_stall = s1_v_r && !s1_adv;
  assign in_fire  = in_valid && !in_stall;

  always_comb begin
    s1_v_nxt = s1_v_r;
    if (in_fire) begin
      s1_v_nxt = 1'b1;
    end else if (s1_fire) begin
      s1_v_nxt = 1'b0;
    end
  end

  // Stage one payload, captured as the store read is issued.
  logic [psf_pkg::IDX_W-1:0]  s1_idx_r;
  logic [AW-1:0]              s1_addr_r;
  logic                       s1_inrange_r;
  logic                       s1_restart_r;
  logic                       s1_new_r;
  logic [psf_pkg::ROLL_W-1:0] s1_roll_r;
  logic [COLORW-1:0]          s1_spark_r;
  logic [AW-1:0]              rd_addr;
  logic                       in_range;

  assign rd_addr  = AW'(in_pixel_index);
  assign in_range = 32'(in_pixel_index) < 32'(PIXELS);

  // ---------------------------------------------------------------------------
  // Stores and forwarding. The write back of stage one can land in the same cycle
  // as the next item's read; if both hit the same pixel, the written colors
  // are kept aside and used in place of the (stale) read data.
  // ---------------------------------------------------------------------------
  logic [COLORW-1:0] tgt_q;
  logic [COLORW-1:0] cur_q;
  logic [COLORW-1:0] tgt_new;
  logic [COLORW-1:0] cur_new;
  logic              wr_en;
  logic              fwd_hit_r;
  logic [COLORW-1:0] fwd_tgt_r;
  logic [COLORW-1:0] fwd_cur_r;

  assign wr_en = s1_fire && s1_inrange_r;

  psf_ram #(
    .WIDTH (COLORW),
    .DEPTH (PIXELS)
  ) u_target_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (s1_addr_r),
    .wdata (tgt_new),
    .re    (in_fire),
    .raddr (rd_addr),
    .rdata (tgt_q)
  );

  psf_ram #(
    .WIDTH (COLORW),
    .DEPTH (PIXELS)
  ) u_current_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (s1_addr_r),
    .wdata (cur_new),
    .re    (in_fire),
    .raddr (rd_addr),
    .rdata (cur_q)
  );

  // The forwarding flag belongs to the item in stage one and drops when the
  // stage empties.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r    <= 1'b0;
      fwd_hit_r <= 1'b0;
    end else begin
      s1_v_r <= s1_v_nxt;
      if (in_fire) begin
        fwd_hit_r <= wr_en && (s1_addr_r == rd_addr);
      end else if (s1_fire) begin
        fwd_hit_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_idx_r     <= in_pixel_index;
      s1_addr_r    <= rd_addr;
      s1_inrange_r <= in_range;
      s1_restart_r <= in_restart;
      s1_new_r     <= in_new_period;
      s1_roll_r    <= in_roll;
      s1_spark_r   <= in_sparkle_color;
      fwd_tgt_r    <= tgt_new;
      fwd_cur_r    <= cur_new;
    end
  end

  // ---------------------------------------------------------------------------
  // Update: restart, target reroll, then a slew-limited move on each channel.
  // ---------------------------------------------------------------------------
  logic [COLORW-1:0]          tgt_old;
  logic [COLORW-1:0]          cur_old;
  logic [COLORW-1:0]          tgt_base;
  logic [COLORW-1:0]          cur_base;
  logic [psf_pkg::THR_W:0]    bg_limit;

  assign tgt_old  = fwd_hit_r ? fwd_tgt_r : tgt_q;
  assign cur_old  = fwd_hit_r ? fwd_cur_r : cur_q;
  assign tgt_base = s1_restart_r ? background_r : tgt_old;
  assign cur_base = s1_restart_r ? background_r : cur_old;
  assign bg_limit = {1'b0, sparkle_thr_r} + {1'b0, reset_extra_r};

  always_comb begin
    tgt_new = tgt_base;
    if (s1_new_r) begin
      if (s1_roll_r < sparkle_thr_r) begin
        tgt_new = s1_spark_r;
      end else if ({1'b0, s1_roll_r} < bg_limit) begin
        tgt_new = background_r;
      end
    end
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      cur_new[c*CW +: CW] = psf_pkg::chan_move(cur_base[c*CW +: CW],
                                               tgt_new[c*CW +: CW], step_r);
    end
  end

  // ---------------------------------------------------------------------------
  // Output register. A pixel outside the store range reports black.
  // ---------------------------------------------------------------------------
  logic [psf_pkg::IDX_W-1:0] out_idx_r;
  logic [COLORW-1:0]         out_color_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (s1_fire) begin
      out_v_r <= 1'b1;
    end else if (!out_stall) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_idx_r   <= s1_idx_r;
      out_color_r <= s1_inrange_r ? cur_new : '0;
    end
  end

  assign out_valid = out_v_r;
  assign out_index = out_idx_r;
  assign out_red   = out_color_r[3*CW-1:2*CW];
  assign out_green = out_color_r[2*CW-1:CW];
  assign out_blue  = out_color_r[CW-1:0];

  // ---------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------
  a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_v_r)
    else $error("input stalled with the update stage empty");

  a_fwd_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    fwd_hit_r |-> s1_v_r)
    else $error("forwarding flagged with no item in the update stage");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire |=> out_v_r)
    else $error("update stage fired but no result became valid");

  a_step_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    step_r != '0)
    else $error("fade step is zero");

  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_stall && !s1_fire) |=> out_v_r)
    else $error("stalled result was dropped");

endmodule
